// ----- design/fptl_pkg.sv -----
// Package for the four-pole TPT low-pass filter: widths, control/status types
// and the stage gain table built at elaboration. Used by every design file.
// No dependencies.
package fptl_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W = 32;
  localparam int STATE_W  = 40;
  localparam int DIFF_W   = STATE_W + 1;
  localparam int HALF_W   = 16;
  localparam int MB_W     = HALF_W + 1;
  localparam int PROD_W   = DIFF_W + MB_W;
  localparam int ACC_W    = PROD_W + HALF_W;
  localparam int CUT_W    = ACC_W - 31 + 1;
  localparam int STAGES   = 4;
  localparam int STAGE_W  = $clog2(STAGES);

  // Gain table shape
  localparam int GAIN_ENTRIES   = 234;
  localparam int SAMPLE_RATE_HZ = 48000;
  localparam int GAIN_SPLIT     = 230;
  localparam int SHIFT_FINE     = 32;
  localparam int SHIFT_COARSE   = 24;
  localparam int TOP_INDEX      = 233;
  localparam int PITCH_CENTER   = 117;
  localparam int STEPS_PER_OCTAVE = 24;
  localparam int BASE_HZ        = 440;
  localparam int IDX_W          = 8;
  localparam int CAP_INT = (TOP_INDEX < GAIN_ENTRIES - 1) ? TOP_INDEX : GAIN_ENTRIES - 1;
  localparam logic [IDX_W-1:0] CAP_INDEX  = IDX_W'(CAP_INT);
  localparam logic [IDX_W-1:0] SPLIT_INDEX = IDX_W'(GAIN_SPLIT);

  // Fixed-point constants for the table build
  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
  localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AC;
  localparam logic [63:0] FS_CLAMPED = (SAMPLE_RATE_HZ < 8000) ? 64'd8000 :
                                       (SAMPLE_RATE_HZ > 192000) ? 64'd192000 :
                                       64'(SAMPLE_RATE_HZ);
  localparam logic [63:0] BASE_SCALE = 64'(BASE_HZ * 16);
  // pi*440/fs in Q66
  localparam logic [63:0] C0 = (PI_Q62 / FS_CLAMPED) * BASE_SCALE +
                               ((PI_Q62 % FS_CLAMPED) * BASE_SCALE) / FS_CLAMPED;

  // Datapath control codes
  typedef enum logic [2:0] {
    MUL_NONE, MUL_CUT_HI, MUL_CUT_LO, MUL_STG_HI, MUL_STG_LO
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_TAKE, OP_CUT, OP_GAIN, OP_DIFF, OP_UPDATE, OP_EMIT
  } dp_op_t;

  // Sequencer steps and jump kinds
  typedef enum logic [3:0] {
    ST_IDLE, ST_CM_HI, ST_CM_LO, ST_CM_ADD, ST_CUT, ST_GAIN,
    ST_DIFF, ST_SM_HI, ST_SM_LO, ST_SM_ADD, ST_UPDATE, ST_EMIT
  } step_t;

  typedef enum logic [2:0] {
    JMP_NEXT, JMP_GOTO, JMP_WAIT_IN, JMP_LOOP, JMP_WAIT_OUT
  } jump_t;

  typedef struct packed {
    mul_sel_t mul;
    acc_op_t  acc;
    dp_op_t   op;
  } ctrl_t;

  typedef struct packed {
    logic stage_last;
    logic out_full;
  } stat_t;

  typedef logic [GAIN_ENTRIES-1:0][31:0] gain_table_t;

  // Q62 product
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // exp(x) by Taylor series, Q62
  function automatic logic [63:0] exp_q62(input logic [63:0] x);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = ONE_Q62;
    term = ONE_Q62;
    for (int k = 1; k < 64 && term != 64'd0; k++) begin
      term = mul_q62(term, x) / 64'(k);
      sum  = sum + term;
    end
    return sum;
  endfunction

  // One table entry: G = sin/(sin+cos) scaled by 2^k
  function automatic logic [31:0] gain_entry(input int idx, input logic [63:0] c0);
    int n;
    int q;
    int sh;
    int kk;
    logic [63:0] r;
    logic [63:0] sat;
    logic [63:0] x;
    logic [63:0] p;
    logic [63:0] theta;
    logic [63:0] term;
    logic [63:0] d;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [127:0] prod;
    logic [127:0] shifted;
    logic signed [63:0] s;
    logic signed [63:0] c;
    logic [31:0] res;
    n  = idx - PITCH_CENTER;
    q  = (n >= 0) ? n / STEPS_PER_OCTAVE :
         -((-n + STEPS_PER_OCTAVE - 1) / STEPS_PER_OCTAVE);
    r  = 64'(n - q * STEPS_PER_OCTAVE);
    kk = (idx < GAIN_SPLIT) ? SHIFT_FINE : SHIFT_COARSE;
    sat = (kk >= 32) ? 64'hFFFF_FFFF : (64'd1 << kk);
    x = ((LN2_Q64 / STEPS_PER_OCTAVE) * r +
         ((LN2_Q64 % STEPS_PER_OCTAVE) * r) / STEPS_PER_OCTAVE) >> 2;
    p = exp_q62(x);
    prod = {64'd0, p} * {64'd0, c0};
    sh = 66 - q;
    shifted = prod >> sh;
    theta = shifted[63:0];
    res = sat[31:0];
    if (shifted[127:64] == 64'd0 && theta < (PI_Q62 >> 1)) begin
      // sin and cos series
      term = ONE_Q62;
      s = 64'sd0;
      c = $signed(ONE_Q62);
      for (int j = 1; j < 64 && term != 64'd0; j++) begin
        term = mul_q62(term, theta) / 64'(j);
        case (j & 3)
          1: s = s + $signed(term);
          2: c = c - $signed(term);
          3: s = s - $signed(term);
          default: c = c + $signed(term);
        endcase
      end
      if (c > 64'sd0 && s >= 64'sd0) begin
        // restoring division s/(s+c), k quotient bits
        d   = $unsigned(s) + $unsigned(c);
        rem = $unsigned(s);
        quo = 64'd0;
        for (int j = 0; j < kk; j++) begin
          rem = rem << 1;
          quo = quo << 1;
          if (rem >= d) begin
            rem = rem - d;
            quo = quo | 64'd1;
          end
        end
        res = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
      end
    end
    return res;
  endfunction

  function automatic gain_table_t build_gain_table();
    gain_table_t t;
    for (int i = 0; i < GAIN_ENTRIES; i++) begin
      t[i] = gain_entry(i, C0);
    end
    return t;
  endfunction

  localparam gain_table_t GAIN_TABLE = build_gain_table();

endpackage

// ----- design/fptl_in_if.sv -----
// Input channel of the four-pole TPT low-pass filter: valid/ready plus the
// sample and cutoff control fields. Depends on fptl_pkg.
interface fptl_in_if;
  import fptl_pkg::*;

  logic valid;
  logic ready;
  logic signed [SAMPLE_W-1:0] audio_sample;
  logic signed [SAMPLE_W-1:0] cutoff_base;
  logic signed [SAMPLE_W-1:0] mod_source;
  logic signed [SAMPLE_W-1:0] mod_amount;

  modport source (
    output valid, audio_sample, cutoff_base, mod_source, mod_amount,
    input  ready
  );

  modport sink (
    input  valid, audio_sample, cutoff_base, mod_source, mod_amount,
    output ready
  );
endinterface

// ----- design/fptl_out_if.sv -----
// Output channel of the four-pole TPT low-pass filter: valid/ready plus the
// filtered sample. Depends on fptl_pkg.
interface fptl_out_if;
  import fptl_pkg::*;

  logic valid;
  logic ready;
  logic signed [SAMPLE_W-1:0] audio_result;

  modport source (
    output valid, audio_result,
    input  ready
  );

  modport sink (
    input  valid, audio_result,
    output ready
  );
endinterface

// ----- design/fptl_sequencer.sv -----
// Microcode sequencer: step counter, control ROM and jump logic that drive
// the filter datapath. Depends on fptl_pkg.
module fptl_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  fptl_pkg::stat_t stat,
  output fptl_pkg::ctrl_t ctrl,
  output logic            take_ready
);
  import fptl_pkg::*;

  typedef struct packed {
    mul_sel_t mul;
    acc_op_t  acc;
    dp_op_t   op;
    jump_t    jmp;
    step_t    target;
  } uword_t;

  // Control program
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{mul: MUL_NONE, acc: ACC_HOLD, op: OP_NONE, jmp: JMP_NEXT, target: ST_IDLE};
    case (s)
      ST_IDLE: begin
        w.op  = OP_TAKE;
        w.jmp = JMP_WAIT_IN;
      end
      ST_CM_HI:  w.mul = MUL_CUT_HI;
      ST_CM_LO: begin
        w.acc = ACC_LOAD;
        w.mul = MUL_CUT_LO;
      end
      ST_CM_ADD: w.acc = ACC_ADD;
      ST_CUT:    w.op  = OP_CUT;
      ST_GAIN:   w.op  = OP_GAIN;
      ST_DIFF:   w.op  = OP_DIFF;
      ST_SM_HI:  w.mul = MUL_STG_HI;
      ST_SM_LO: begin
        w.acc = ACC_LOAD;
        w.mul = MUL_STG_LO;
      end
      ST_SM_ADD: w.acc = ACC_ADD;
      ST_UPDATE: begin
        w.op     = OP_UPDATE;
        w.jmp    = JMP_LOOP;
        w.target = ST_DIFF;
      end
      ST_EMIT: begin
        w.op     = OP_EMIT;
        w.jmp    = JMP_WAIT_OUT;
        w.target = ST_IDLE;
      end
      default: w.jmp = JMP_GOTO;
    endcase
    return w;
  endfunction

  step_t  pc;
  step_t  pc_next;
  uword_t word;
  logic   hold;

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Next step and gated control word
  always_comb begin
    word = ucode(pc);
    hold = 1'b0;
    pc_next = step_t'(4'(pc + 4'd1));
    case (word.jmp)
      JMP_NEXT: ;
      JMP_GOTO: pc_next = word.target;
      JMP_WAIT_IN: begin
        hold = !in_valid;
        if (hold) pc_next = pc;
      end
      JMP_LOOP: begin
        if (!stat.stage_last) pc_next = word.target;
      end
      JMP_WAIT_OUT: begin
        hold = stat.out_full;
        pc_next = hold ? pc : word.target;
      end
      default: pc_next = ST_IDLE;
    endcase
    ctrl.mul   = word.mul;
    ctrl.acc   = word.acc;
    ctrl.op    = hold ? OP_NONE : word.op;
    take_ready = (word.op == OP_TAKE);
  end

endmodule

// ----- design/fptl_datapath.sv -----
// Filter datapath: input capture, shared 41x17 multiplier, accumulator,
// gain table read, four stage memories and the output register. Depends on fptl_pkg.
module fptl_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fptl_pkg::ctrl_t                      ctrl,
  input  logic signed [fptl_pkg::SAMPLE_W-1:0] audio_sample,
  input  logic signed [fptl_pkg::SAMPLE_W-1:0] cutoff_base,
  input  logic signed [fptl_pkg::SAMPLE_W-1:0] mod_source,
  input  logic signed [fptl_pkg::SAMPLE_W-1:0] mod_amount,
  input  logic                                 result_ready,
  output logic                                 result_valid,
  output logic signed [fptl_pkg::SAMPLE_W-1:0] audio_result,
  output fptl_pkg::stat_t                      stat
);
  import fptl_pkg::*;

  // Captured word
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [SAMPLE_W-1:0] base;
  logic signed [SAMPLE_W-1:0] source;
  logic signed [SAMPLE_W-1:0] amount;

  // Working registers
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [DIFF_W-1:0]  diff;
  logic        [IDX_W-1:0]   idx;
  logic        [31:0]        gain;
  logic                      coarse;
  logic        [STAGE_W-1:0] sidx;
  logic signed [STATE_W-1:0] stage_in;
  logic signed [STATE_W-1:0] z [STAGES];

  // Combinational values
  logic signed [DIFF_W-1:0]  mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [CUT_W-1:0]   cut_sum;
  logic        [30:0]        cut_clamped;
  logic        [IDX_W-1:0]   cut_idx;
  logic signed [STATE_W-1:0] z_cur;
  logic signed [STATE_W-1:0] v;
  logic signed [STATE_W-1:0] y;
  logic signed [STATE_W-1:0] pre_scaled;
  logic signed [SAMPLE_W-1:0] sat_out;

  assign z_cur = z[sidx];

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul)
      MUL_CUT_HI: begin
        mul_a = {{(DIFF_W-SAMPLE_W){amount[SAMPLE_W-1]}}, amount};
        mul_b = {source[SAMPLE_W-1], source[SAMPLE_W-1:HALF_W]};
      end
      MUL_CUT_LO: begin
        mul_a = {{(DIFF_W-SAMPLE_W){amount[SAMPLE_W-1]}}, amount};
        mul_b = {1'b0, source[HALF_W-1:0]};
      end
      MUL_STG_HI: begin
        mul_a = diff;
        mul_b = {1'b0, gain[31:HALF_W]};
      end
      MUL_STG_LO: begin
        mul_a = diff;
        mul_b = {1'b0, gain[HALF_W-1:0]};
      end
      default: ;
    endcase
  end

  // Cutoff: floor(amount*source/2^31) + base, clamped, then table index
  always_comb begin
    cut_sum = $signed(acc[ACC_W-1:31]) +
              $signed({{(CUT_W-SAMPLE_W){base[SAMPLE_W-1]}}, base});
    if (cut_sum[CUT_W-1]) begin
      cut_clamped = '0;
    end else if (|cut_sum[CUT_W-2:31]) begin
      cut_clamped = '1;
    end else begin
      cut_clamped = cut_sum[30:0];
    end
    cut_idx = cut_clamped[30:23];
    if (cut_idx > CAP_INDEX) cut_idx = CAP_INDEX;
  end

  // Stage arithmetic: v = floor(d*G/2^k), y = v + z
  always_comb begin
    v = coarse ? acc[SHIFT_COARSE+STATE_W-1:SHIFT_COARSE]
               : acc[SHIFT_FINE+STATE_W-1:SHIFT_FINE];
    y = v + z_cur;
  end

  // Input pre-scale: x-1 for positive x
  always_comb begin
    pre_scaled = {{(STATE_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    if (!sample[SAMPLE_W-1] && sample != '0) pre_scaled = pre_scaled - STATE_W'(1);
  end

  // Output saturation to 32 bits
  always_comb begin
    if (!stage_in[STATE_W-1] && |stage_in[STATE_W-2:SAMPLE_W-1]) begin
      sat_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (stage_in[STATE_W-1] && !(&stage_in[STATE_W-2:SAMPLE_W-1])) begin
      sat_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_out = stage_in[SAMPLE_W-1:0];
    end
  end

  // Multiplier and accumulator
  always_ff @(posedge clk) begin
    if (ctrl.mul != MUL_NONE) prod <= mul_a * mul_b;
    case (ctrl.acc)
      ACC_LOAD: acc <= {prod, {HALF_W{1'b0}}};
      ACC_ADD:  acc <= acc + {{HALF_W{prod[PROD_W-1]}}, prod};
      default: ;
    endcase
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_TAKE: begin
        sample <= audio_sample;
        base   <= cutoff_base;
        source <= mod_source;
        amount <= mod_amount;
      end
      OP_CUT:  idx <= cut_idx;
      OP_GAIN: begin
        gain     <= GAIN_TABLE[idx];
        coarse   <= (idx >= SPLIT_INDEX);
        stage_in <= pre_scaled;
      end
      OP_DIFF:   diff <= {stage_in[STATE_W-1], stage_in} - {z_cur[STATE_W-1], z_cur};
      OP_UPDATE: stage_in <= y;
      OP_EMIT:   audio_result <= sat_out;
      default: ;
    endcase
  end

  // Stage memories and stage counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) z[i] <= '0;
      sidx <= '0;
    end else begin
      case (ctrl.op)
        OP_GAIN: sidx <= '0;
        OP_UPDATE: begin
          z[sidx] <= y + v;
          sidx    <= sidx + STAGE_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.op == OP_EMIT) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  assign stat.stage_last = (sidx == STAGE_W'(STAGES - 1));
  assign stat.out_full   = result_valid && !result_ready;

endmodule

// ----- design/four_pole_tpt_lowpass.sv -----
// Four-pole TPT low-pass filter, top level: microcode sequencer plus datapath.
// Depends on fptl_pkg, fptl_in_if, fptl_out_if, fptl_sequencer, fptl_datapath.
//
// Usage:
//   samples: one word per audio sample with cutoff_base, mod_source and
//            mod_amount; taken when valid and ready are both high.
//   results: one filtered word per input word, same order.
//   Ready is high only while the sequencer sits on its idle step, so one
//   sample is in work at a time. The program runs 27 steps per sample:
//   one accept step, three for the cutoff multiply (two 41x17 partial
//   products on the shared multiplier), two for index and gain lookup, five
//   per pole for four poles, one to emit.
//   The result sits in an output register; the next sample is accepted
//   while it waits. If the receiver still stalls when the next result is
//   ready, the emit step waits and nothing is lost.
//   Reset clears the four pole memories, the step counter and results.valid;
//   the gain table is a constant and needs no fill.
module four_pole_tpt_lowpass (
  input logic      clk,
  input logic      rst,
  fptl_in_if.sink  samples,
  fptl_out_if.source results
);
  import fptl_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  take_ready;

  fptl_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (samples.valid),
    .stat       (stat),
    .ctrl       (ctrl),
    .take_ready (take_ready)
  );

  assign samples.ready = take_ready;

  fptl_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .audio_sample (samples.audio_sample),
    .cutoff_base  (samples.cutoff_base),
    .mod_source   (samples.mod_source),
    .mod_amount   (samples.mod_amount),
    .result_ready (results.ready),
    .result_valid (results.valid),
    .audio_result (results.audio_result),
    .stat         (stat)
  );

endmodule

// ----- design/fptl_checker.sv -----
// Port-level checks for the four-pole TPT low-pass filter, bound to the top.
// Depends on fptl_pkg and four_pole_tpt_lowpass.
module fptl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fptl_pkg::SAMPLE_W-1:0] audio_result
);
  import fptl_pkg::*;

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(audio_result))
    else $error("stalled result changed");

  // Only one word in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  // A result never appears right after a word is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared before the filter ran");

endmodule

bind four_pole_tpt_lowpass fptl_checker u_fptl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (samples.valid),
  .in_ready     (samples.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .audio_result (results.audio_result)
);
